[src/rmq_pkg.sv]
// Shared widths, constants and types for the rotation matrix to quaternion block.
// Used by every module under src; depends on nothing.
package rmq_pkg;

  localparam int FRAC_BITS = 16;
  localparam int FW        = 18;
  // Magnitude of a quaternion component before normalization.
  localparam int MW        = ((FRAC_BITS > FW) ? FRAC_BITS : FW) + 2;
  localparam int TW        = MW + 1;
  localparam int NW        = 2 * MW + 2;
  localparam int SQ_ST     = NW / 2;
  localparam int RW        = MW + 1;
  localparam int QW        = FW;
  localparam int NUMW      = MW + FRAC_BITS + 1;
  localparam int DW        = ((NUMW > RW + QW - 1) ? NUMW : (RW + QW - 1)) + 1;
  localparam int QDEPTH    = 4;
  localparam int QAW       = $clog2(QDEPTH);
  localparam int IN_BYTES  = (9 * FW + 7) / 8;
  localparam int OUT_BYTES = (4 * FW + 7) / 8;

  localparam logic signed [TW-1:0] ONE = TW'(1) << FRAC_BITS;
  localparam logic [QW:0] OUT_MAX = (QW + 1)'((1 << (FW - 1)) - 1);
  localparam logic [QW:0] OUT_MIN_MAG = (QW + 1)'(1 << (FW - 1));

  typedef struct packed {
    logic [3:0]         sgn;
    logic [3:0][MW-1:0] mag;
  } vec_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_st_t;

endpackage

[src/rmq_front.sv]
// Front end: forms the four trace sums, picks the largest and builds the raw quaternion.
// Depends on rmq_pkg.
module rmq_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [9*rmq_pkg::FW-1:0]       in_data_i,
  input  logic                           q_full_i,
  output logic                           push_o,
  output rmq_pkg::vec_t                  push_data_o,
  output logic                           busy_o
);

  localparam int TW = rmq_pkg::TW;
  localparam int FW = rmq_pkg::FW;
  localparam int MW = rmq_pkg::MW;

  logic signed [TW-1:0] m [9];
  logic signed [TW-1:0] t [4];
  logic signed [TW-1:0] v [4];
  logic [1:0]           best;
  rmq_pkg::vec_t        vec_d, vec_q;
  logic                 vld_q;
  logic                 adv;

  always_comb begin
    for (int i = 0; i < 9; i++) begin
      m[i] = {{(TW-FW){in_data_i[i*FW+FW-1]}}, in_data_i[i*FW +: FW]};
    end
    // Element index is column * 3 + row.
    t[0] = rmq_pkg::ONE + m[0] + m[4] + m[8];
    t[1] = rmq_pkg::ONE + m[0] - m[4] - m[8];
    t[2] = rmq_pkg::ONE - m[0] + m[4] - m[8];
    t[3] = rmq_pkg::ONE - m[0] - m[4] + m[8];
    best = 2'd0;
    for (int k = 1; k < 4; k++) begin
      if (t[k] > t[best]) best = 2'(k);
    end
    unique case (best)
      2'd0: begin
        v[0] = t[0];        v[1] = m[5] - m[7];
        v[2] = m[6] - m[2]; v[3] = m[1] - m[3];
      end
      2'd1: begin
        v[0] = m[5] - m[7]; v[1] = t[1];
        v[2] = m[1] + m[3]; v[3] = m[6] + m[2];
      end
      2'd2: begin
        v[0] = m[6] - m[2]; v[1] = m[1] + m[3];
        v[2] = t[2];        v[3] = m[5] + m[7];
      end
      default: begin
        v[0] = m[1] - m[3]; v[1] = m[6] + m[2];
        v[2] = m[5] + m[7]; v[3] = t[3];
      end
    endcase
    for (int k = 0; k < 4; k++) begin
      vec_d.sgn[k] = v[k][TW-1];
      vec_d.mag[k] = v[k][TW-1] ? MW'(-v[k]) : MW'(v[k]);
    end
  end

  assign push_o      = vld_q && !q_full_i;
  assign adv         = !vld_q || !q_full_i;
  assign in_ready_o  = adv;
  assign push_data_o = vec_q;
  assign busy_o      = vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (adv) begin
      vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && in_valid_i) begin
      vec_q <= vec_d;
    end
  end

endmodule

[src/rmq_fifo.sv]
// Short queue that decouples the front end from the normalizing back end.
// Depends on rmq_pkg.
module rmq_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  rmq_pkg::vec_t      push_data_i,
  input  logic               pop_i,
  output rmq_pkg::vec_t      pop_data_o,
  output rmq_pkg::fifo_st_t  st_o
);

  localparam int AW = rmq_pkg::QAW;

  rmq_pkg::vec_t  mem_q [rmq_pkg::QDEPTH];
  logic [AW-1:0]  wptr_q, rptr_q;
  logic [AW:0]    cnt_q;

  assign st_o.full  = (cnt_q == (AW+1)'(rmq_pkg::QDEPTH));
  assign st_o.empty = (cnt_q == '0);
  assign pop_data_o = mem_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) wptr_q <= wptr_q + 1'b1;
      if (pop_i)  rptr_q <= rptr_q + 1'b1;
      unique case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wptr_q] <= push_data_i;
  end

endmodule

[src/rmq_back.sv]
// Back end: squared norm, bit-per-stage square root, bit-per-stage division, saturation.
// Depends on rmq_pkg.
module rmq_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      q_empty_i,
  input  rmq_pkg::vec_t             q_data_i,
  output logic                      pop_o,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [4*rmq_pkg::FW-1:0]  out_data_o
);

  localparam int MW = rmq_pkg::MW;
  localparam int NW = rmq_pkg::NW;
  localparam int SQ = rmq_pkg::SQ_ST;
  localparam int RW = rmq_pkg::RW;
  localparam int QW = rmq_pkg::QW;
  localparam int DW = rmq_pkg::DW;
  localparam int FW = rmq_pkg::FW;
  localparam int F  = rmq_pkg::FRAC_BITS;

  logic en;

  logic                a_vld_q, b_vld_q, c_vld_q;
  rmq_pkg::vec_t       a_vec_q, b_vec_q, c_vec_q;
  logic [2*MW-1:0]     b_sq_q [4];
  logic [NW-1:0]       c_n_q;

  logic                s_vld_q [SQ];
  rmq_pkg::vec_t       s_vec_q [SQ];
  logic [NW-1:0]       s_n_q [SQ], s_r_q [SQ], s_n_d [SQ], s_r_d [SQ];

  logic                d_vld_q [QW];
  logic [3:0]          d_sgn_q [QW];
  logic [RW-1:0]       d_r_q [QW];
  logic [DW-1:0]       d_rem_q [QW][4], d_rem_d [QW][4];
  logic [QW-1:0]       d_q_q [QW][4], d_q_d [QW][4];

  logic                out_vld_q;
  logic [4*FW-1:0]     out_q, out_d;
  logic [RW-1:0]       r_in;

  assign en          = !out_vld_q || out_ready_i;
  assign pop_o       = en && !q_empty_i;
  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;
  assign r_in        = s_r_q[SQ-1][RW-1:0];

  // Square root, one result bit per stage.
  always_comb begin
    logic [NW-1:0] n, r, bit_v;
    for (int i = 0; i < SQ; i++) begin
      n     = (i == 0) ? c_n_q : s_n_q[(i == 0) ? 0 : i-1];
      r     = (i == 0) ? '0    : s_r_q[(i == 0) ? 0 : i-1];
      bit_v = NW'(1) << (NW - 2 - 2*i);
      if (n >= r + bit_v) begin
        s_n_d[i] = n - (r + bit_v);
        s_r_d[i] = (r >> 1) + bit_v;
      end else begin
        s_n_d[i] = n;
        s_r_d[i] = r >> 1;
      end
    end
  end

  // Restoring division, one quotient bit per stage, four lanes.
  always_comb begin
    logic [DW-1:0] rem, dv;
    logic [RW-1:0] r;
    for (int j = 0; j < QW; j++) begin
      r  = (j == 0) ? r_in : d_r_q[(j == 0) ? 0 : j-1];
      dv = DW'(r) << (QW - 1 - j);
      for (int c = 0; c < 4; c++) begin
        if (j == 0) begin
          rem       = (DW'(s_vec_q[SQ-1].mag[c]) << F) + DW'(r_in >> 1);
          d_q_d[j][c] = '0;
        end else begin
          rem       = d_rem_q[(j == 0) ? 0 : j-1][c];
          d_q_d[j][c] = d_q_q[(j == 0) ? 0 : j-1][c];
        end
        if (rem >= dv) begin
          d_rem_d[j][c] = rem - dv;
          d_q_d[j][c][QW-1-j] = 1'b1;
        end else begin
          d_rem_d[j][c] = rem;
        end
      end
    end
  end

  // Restore the sign and saturate to the output range.
  always_comb begin
    logic [QW:0] mq;
    for (int c = 0; c < 4; c++) begin
      mq = {1'b0, d_q_q[QW-1][c]};
      if (d_sgn_q[QW-1][c]) begin
        out_d[c*FW +: FW] = (mq > rmq_pkg::OUT_MIN_MAG) ? FW'(rmq_pkg::OUT_MIN_MAG)
                                                        : FW'(-mq);
      end else begin
        out_d[c*FW +: FW] = (mq > rmq_pkg::OUT_MAX) ? FW'(rmq_pkg::OUT_MAX) : FW'(mq);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q   <= 1'b0;
      b_vld_q   <= 1'b0;
      c_vld_q   <= 1'b0;
      out_vld_q <= 1'b0;
      for (int i = 0; i < SQ; i++) s_vld_q[i] <= 1'b0;
      for (int j = 0; j < QW; j++) d_vld_q[j] <= 1'b0;
    end else if (en) begin
      a_vld_q <= !q_empty_i;
      b_vld_q <= a_vld_q;
      c_vld_q <= b_vld_q;
      s_vld_q[0] <= c_vld_q;
      for (int i = 1; i < SQ; i++) s_vld_q[i] <= s_vld_q[i-1];
      d_vld_q[0] <= s_vld_q[SQ-1];
      for (int j = 1; j < QW; j++) d_vld_q[j] <= d_vld_q[j-1];
      out_vld_q <= d_vld_q[QW-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_vec_q <= q_data_i;
      b_vec_q <= a_vec_q;
      for (int c = 0; c < 4; c++) b_sq_q[c] <= a_vec_q.mag[c] * a_vec_q.mag[c];
      c_vec_q <= b_vec_q;
      c_n_q   <= NW'(b_sq_q[0]) + NW'(b_sq_q[1]) + NW'(b_sq_q[2]) + NW'(b_sq_q[3]);
      s_vec_q[0] <= c_vec_q;
      for (int i = 1; i < SQ; i++) s_vec_q[i] <= s_vec_q[i-1];
      for (int i = 0; i < SQ; i++) begin
        s_n_q[i] <= s_n_d[i];
        s_r_q[i] <= s_r_d[i];
      end
      d_sgn_q[0] <= s_vec_q[SQ-1].sgn;
      d_r_q[0]   <= r_in;
      for (int j = 1; j < QW; j++) begin
        d_sgn_q[j] <= d_sgn_q[j-1];
        d_r_q[j]   <= d_r_q[j-1];
      end
      for (int j = 0; j < QW; j++) begin
        for (int c = 0; c < 4; c++) begin
          d_rem_q[j][c] <= d_rem_d[j][c];
          d_q_q[j][c]   <= d_q_d[j][c];
        end
      end
      out_q <= out_d;
    end
  end

endmodule

[src/rotation_matrix_to_quaternion_top.sv]
// Rotation matrix to unit quaternion: one 3x3 matrix in, one quaternion out per item.
// After the front register come 1 queue write, 3 norm stages, 21 square root stages,
// 18 division stages and 1 output register. Throughput is one item per cycle while the
// sink does not hold the output; each root and quotient bit has its own stage. Reset
// (rst_ni low, asynchronous) empties the pipeline and the queue.
// Depends on rmq_pkg, rmq_front, rmq_fifo and rmq_back.
module rotation_matrix_to_quaternion_top (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  s_axis_tvalid_i,
  output logic                                  s_axis_tready_o,
  // col0_row0, col0_row1, col0_row2, col1_row0, ..., col2_row2 (18 bits each), zero pad
  input  logic [8*rmq_pkg::IN_BYTES-1:0]        s_axis_tdata_i,
  output logic                                  m_axis_tvalid_o,
  input  logic                                  m_axis_tready_i,
  // quat_w, quat_x, quat_y, quat_z (18 bits each)
  output logic [8*rmq_pkg::OUT_BYTES-1:0]       m_axis_tdata_o
);

  localparam int FW = rmq_pkg::FW;
  localparam logic signed [FW-1:0] HALF = FW'(1) << (rmq_pkg::FRAC_BITS - 1);

  logic               push, pop, front_busy;
  rmq_pkg::vec_t      push_data, pop_data;
  rmq_pkg::fifo_st_t  q_st;
  logic [4*FW-1:0]    out_data;
  logic [3:0]         comp_big;

  // The front end classifies each matrix by its largest trace and forms the raw vector.
  rmq_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_data_i   (s_axis_tdata_i[9*FW-1:0]),
    .q_full_i    (q_st.full),
    .push_o      (push),
    .push_data_o (push_data),
    .busy_o      (front_busy)
  );

  // The queue lets the front keep taking items while the back end is held by the sink, until it fills.
  rmq_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .st_o        (q_st)
  );

  // The back end normalizes the vector to unit length and saturates it.
  rmq_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_st.empty),
    .q_data_i    (pop_data),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_data_o  (out_data)
  );

  assign m_axis_tdata_o = (8*rmq_pkg::OUT_BYTES)'(out_data);

  // A component counts as large when its magnitude reaches one half.
  always_comb begin
    logic signed [FW-1:0] comp;
    for (int c = 0; c < 4; c++) begin
      comp        = out_data[c*FW +: FW];
      comp_big[c] = (comp >= HALF) || (comp <= -HALF);
    end
  end

  // The front only refuses input when its register holds an item the full queue cannot take.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> (front_busy && q_st.full))
    else $error("front stalled without a full queue");

  // The back end never pops an empty queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !q_st.empty)
    else $error("pop from empty queue");

  // A unit quaternion has a component of magnitude at least one half.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (|comp_big))
    else $error("normalized output too small");

endmodule

[test/tb_rotation_matrix_to_quaternion_top.sv]
// Testbench for the rotation matrix to quaternion block: drives matrices on the input stream
// and checks every quaternion against a predictor built into this file or a directed expectation.
// Depends on rmq_pkg and rotation_matrix_to_quaternion_top.
module tb_rotation_matrix_to_quaternion_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FW        = rmq_pkg::FW;
  localparam int FRAC_BITS = rmq_pkg::FRAC_BITS;
  localparam int IN_BYTES  = rmq_pkg::IN_BYTES;
  localparam int OUT_BYTES = rmq_pkg::OUT_BYTES;

  localparam int MAX_CYCLES = 400000;
  localparam int DRAIN_CYCLES = 60;
  localparam int N_RANDOM = 2000;

  // One matrix, indexed by column then row.
  typedef logic signed [FW-1:0] elem_t;
  typedef elem_t mat_t [9];
  typedef struct packed {
    logic [FW-1:0] w, x, y, z;
  } quat_t;

  // One directed row: the matrix and, where it is obvious, the expected quaternion.
  typedef struct {
    logic [FW-1:0] e [9];
    logic          has_exp;
    quat_t         exp_q;
  } dir_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid_i = 1'b0;
  logic s_axis_tready_o;
  logic [8*IN_BYTES-1:0] s_axis_tdata_i = '0;
  logic m_axis_tvalid_o;
  logic m_axis_tready_i = 1'b0;
  logic [8*OUT_BYTES-1:0] m_axis_tdata_o;

  quat_t quat_fifo [$];
  int    n_errors = 0;
  int    n_checked = 0;
  int    n_sent = 0;
  longint cycle_cnt = 0;
  bit    calm = 1'b0;

  rotation_matrix_to_quaternion_top dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Global watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > MAX_CYCLES) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic report(input string what, input longint got, input longint want);
    n_errors++;
    $display("mismatch %s: got %0d expected %0d", what, got, want);
  endtask

  function automatic longint unsigned root_floor(input longint unsigned n);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // Normalize one component: magnitude rounded half up, sign restored, saturated.
  function automatic logic [FW-1:0] unit_comp(input longint v, input longint unsigned r);
    longint unsigned mg, q;
    longint res;
    mg = (v < 0) ? -v : v;
    q = ((mg << FRAC_BITS) + (r >> 1)) / r;
    if (v < 0) res = (q > 131072) ? -131072 : -longint'(q);
    else       res = (q > 131071) ? 131071 : longint'(q);
    return res[FW-1:0];
  endfunction

  // Shepperd's method: largest trace picks the case, lowest index wins a tie.
  function automatic quat_t matrix_to_quat(input logic [FW-1:0] e [9]);
    longint m [3][3];
    longint t [4];
    longint v [4];
    longint unsigned n, r, a;
    int best;
    quat_t q;
    for (int c = 0; c < 3; c++)
      for (int k = 0; k < 3; k++) m[c][k] = longint'(signed'(e[c*3+k]));
    t[0] = (64'sd1 << FRAC_BITS) + m[0][0] + m[1][1] + m[2][2];
    t[1] = (64'sd1 << FRAC_BITS) + m[0][0] - m[1][1] - m[2][2];
    t[2] = (64'sd1 << FRAC_BITS) - m[0][0] + m[1][1] - m[2][2];
    t[3] = (64'sd1 << FRAC_BITS) - m[0][0] - m[1][1] + m[2][2];
    best = 0;
    for (int k = 1; k < 4; k++) if (t[k] > t[best]) best = k;
    case (best)
      0: begin
        v[0] = t[0]; v[1] = m[1][2] - m[2][1];
        v[2] = m[2][0] - m[0][2]; v[3] = m[0][1] - m[1][0];
      end
      1: begin
        v[0] = m[1][2] - m[2][1]; v[1] = t[1];
        v[2] = m[0][1] + m[1][0]; v[3] = m[2][0] + m[0][2];
      end
      2: begin
        v[0] = m[2][0] - m[0][2]; v[1] = m[0][1] + m[1][0];
        v[2] = t[2]; v[3] = m[1][2] + m[2][1];
      end
      default: begin
        v[0] = m[0][1] - m[1][0]; v[1] = m[2][0] + m[0][2];
        v[2] = m[1][2] + m[2][1]; v[3] = t[3];
      end
    endcase
    n = 0;
    for (int k = 0; k < 4; k++) begin
      a = (v[k] < 0) ? -v[k] : v[k];
      n += a * a;
    end
    r = root_floor(n);
    if (r == 0) r = 1;
    q.w = unit_comp(v[0], r);
    q.x = unit_comp(v[1], r);
    q.y = unit_comp(v[2], r);
    q.z = unit_comp(v[3], r);
    return q;
  endfunction

  // Hand one matrix to the block and hold it until it is taken.
  task automatic send_matrix(input logic [FW-1:0] e [9]);
    logic [8*IN_BYTES-1:0] word;
    word = '0;
    for (int i = 0; i < 9; i++) word[i*FW +: FW] = e[i];
    if (!calm && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i <= word;
    quat_fifo.push_back(matrix_to_quat(e));
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    n_sent++;
  endtask

  // Output side: random stall bursts, checked at accepting edges.
  initial begin
    quat_t got, want;
    @(posedge rst_ni);
    forever begin
      if (!calm && $urandom_range(0, 4) == 0) begin
        m_axis_tready_i <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
      end
      m_axis_tready_i <= 1'b1;
      @(posedge clk_i);
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        got = m_axis_tdata_o[4*FW-1:0];
        got = '{w: m_axis_tdata_o[0 +: FW], x: m_axis_tdata_o[FW +: FW],
                y: m_axis_tdata_o[2*FW +: FW], z: m_axis_tdata_o[3*FW +: FW]};
        if (quat_fifo.size() == 0) begin
          report("unexpected quaternion", 0, 0);
        end else begin
          want = quat_fifo.pop_front();
          if (got.w !== want.w) report("quat_w", signed'(got.w), signed'(want.w));
          if (got.x !== want.x) report("quat_x", signed'(got.x), signed'(want.x));
          if (got.y !== want.y) report("quat_y", signed'(got.y), signed'(want.y));
          if (got.z !== want.z) report("quat_z", signed'(got.z), signed'(want.z));
          n_checked++;
        end
      end
    end
  end

  function automatic elem_t rand_elem(input int mode);
    case (mode)
      0: return elem_t'($urandom_range(0, 262143));
      1: return elem_t'(int'($urandom_range(0, 131072)) - 65536);
      default: return ($urandom_range(0, 1)) ? elem_t'(131071) : elem_t'(-131072);
    endcase
  endfunction

  initial begin
    dir_row_t dir_tab [$];
    dir_row_t row;
    logic [FW-1:0] e [9];
    int mode;
    real ang, cs, sn;
    int ax;

    // Identity gives w = 1; rotations of pi about each axis reach the other three cases.
    row.has_exp = 1'b1;
    row.e = '{18'h10000, 0, 0, 0, 18'h10000, 0, 0, 0, 18'h10000};
    row.exp_q = '{w: 18'h10000, x: 0, y: 0, z: 0};
    dir_tab.push_back(row);
    row.e = '{18'h10000, 0, 0, 0, -18'sh10000, 0, 0, 0, -18'sh10000};
    row.exp_q = '{w: 0, x: 18'h10000, y: 0, z: 0};
    dir_tab.push_back(row);
    row.e = '{-18'sh10000, 0, 0, 0, 18'h10000, 0, 0, 0, -18'sh10000};
    row.exp_q = '{w: 0, x: 0, y: 18'h10000, z: 0};
    dir_tab.push_back(row);
    row.e = '{-18'sh10000, 0, 0, 0, -18'sh10000, 0, 0, 0, 18'h10000};
    row.exp_q = '{w: 0, x: 0, y: 0, z: 18'h10000};
    dir_tab.push_back(row);
    // Zero matrix: all traces tie, the first wins.
    row.e = '{0, 0, 0, 0, 0, 0, 0, 0, 0};
    row.exp_q = '{w: 18'h10000, x: 0, y: 0, z: 0};
    dir_tab.push_back(row);
    // The rest go through the predictor: field extremes and non-rotations.
    row.has_exp = 1'b0;
    row.e = '{18'h1FFFF, 18'h1FFFF, 18'h1FFFF, 18'h1FFFF, 18'h1FFFF, 18'h1FFFF,
              18'h1FFFF, 18'h1FFFF, 18'h1FFFF};
    dir_tab.push_back(row);
    row.e = '{18'h20000, 18'h20000, 18'h20000, 18'h20000, 18'h20000, 18'h20000,
              18'h20000, 18'h20000, 18'h20000};
    dir_tab.push_back(row);
    row.e = '{18'h20000, 18'h1FFFF, 18'h20000, 18'h1FFFF, 18'h20000, 18'h1FFFF,
              18'h20000, 18'h1FFFF, 18'h20000};
    dir_tab.push_back(row);
    row.e = '{18'h1FFFF, 18'h20000, 18'h1FFFF, 18'h20000, 18'h1FFFF, 18'h20000,
              18'h1FFFF, 18'h20000, 18'h1FFFF};
    dir_tab.push_back(row);
    // Ties between the x, y and z cases, among all four cases, and between w and x.
    row.e = '{-18'sh8000, 5, 7, 9, -18'sh8000, 11, 13, 17, -18'sh8000};
    dir_tab.push_back(row);
    row.e = '{0, 100, 200, 300, 0, 400, 500, 600, 0};
    dir_tab.push_back(row);
    row.e = '{18'h10000, 3, -18'sh3, 5, 0, 8, 1, 2, 0};
    dir_tab.push_back(row);

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[i]) begin
      send_matrix(dir_tab[i].e);
      if (dir_tab[i].has_exp) quat_fifo[$] = dir_tab[i].exp_q;
    end

    // Let everything drain before the random part.
    s_axis_tvalid_i <= 1'b0;
    while (quat_fifo.size() != 0) @(posedge clk_i);

    for (int n = 0; n < N_RANDOM; n++) begin
      if (n == N_RANDOM - 300) calm = 1'b1;
      mode = $urandom_range(0, 9);
      if (mode < 6) begin
        // Well-formed rotation about one axis, possibly with one element replaced by a random value.
        ang = ($urandom_range(0, 62831) / 10000.0);
        cs = $cos(ang);
        sn = $sin(ang);
        ax = $urandom_range(0, 2);
        for (int c = 0; c < 3; c++)
          for (int k = 0; k < 3; k++) begin
            real val;
            int i1, i2;
            i1 = (ax + 1) % 3;
            i2 = (ax + 2) % 3;
            if (c == ax || k == ax) val = (c == k) ? 1.0 : 0.0;
            else if (c == k) val = cs;
            else if (c == i1) val = sn;
            else val = -sn;
            e[c*3+k] = elem_t'(int'($rtoi(val * 65536.0)));
          end
        if (mode == 5) e[$urandom_range(0, 8)] = rand_elem(0);
      end else begin
        for (int i = 0; i < 9; i++) e[i] = rand_elem(mode - 6 > 2 ? 2 : mode - 6);
      end
      send_matrix(e);
      if (n == 1000) begin
        s_axis_tvalid_i <= 1'b0;
        while (quat_fifo.size() != 0) @(posedge clk_i);
      end
    end
    s_axis_tvalid_i <= 1'b0;

    while (quat_fifo.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("Sent %0d matrices (axis rotations, all trace cases, extremes, noise);", n_sent);
    $display("%0d quaternions checked, %0d mismatches.", n_checked, n_errors);
    if (n_errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
